>>> sv/nearest_three_neighbour_select_macros.svh
// assertion macros shared by the checker
`ifndef NEAREST_THREE_NEIGHBOUR_SELECT_MACROS_SVH
`define NEAREST_THREE_NEIGHBOUR_SELECT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NTS_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NTS_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nts_pkg.sv
// shared types and constants for the nearest neighbour selector
`timescale 1ns / 1ps

package nts_pkg;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int RSQ_W    = 2 * RADIUS_W;

    localparam logic [RADIUS_W-1:0] AWARENESS_RESET = 15'd800;
    localparam logic [RADIUS_W-1:0] PREDATOR_RESET  = 15'd10240;

    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_POINT  = 2'd1,
        MODE_FINISH = 2'd2
    } mode_t;

    typedef enum logic {
        REG_AWARENESS = 1'b0,
        REG_PREDATOR  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } slot_t;

    typedef struct packed {
        logic clear;
        logic offer;
    } bank_cmd_t;

endpackage

>>> sv/nts_slot_bank.sv
// bank of kept neighbours with fill-first and replace-farthest update
`timescale 1ns / 1ps

module nts_slot_bank #(
    parameter int KEEP_COUNT = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nts_pkg::bank_cmd_t                  cmd,
    input  nts_pkg::slot_t                      cand,
    input  logic [nts_pkg::DIST_W-1:0]          cand_dist,
    output nts_pkg::slot_t [KEEP_COUNT-1:0]     slots,
    output logic [KEEP_COUNT-1:0]               slot_valid
);

    nts_pkg::slot_t [KEEP_COUNT-1:0]            slot_reg;
    logic [KEEP_COUNT-1:0][nts_pkg::DIST_W-1:0] dist_reg;
    logic [KEEP_COUNT-1:0]                      valid_reg;
    logic [KEEP_COUNT-1:0]                      valid_next;
    logic [KEEP_COUNT-1:0]                      wr_sel;

    // lowest empty slot first, else farthest slot (lowest on ties) if strictly closer
    always_comb
    begin
        logic                       found;
        logic [KEEP_COUNT-1:0]      empty_sel;
        logic [KEEP_COUNT-1:0]      far_sel;
        logic [nts_pkg::DIST_W-1:0] far_dist;
        found     = 1'b0;
        empty_sel = '0;
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            if (!valid_reg[i] && !found)
            begin
                empty_sel[i] = 1'b1;
                found        = 1'b1;
            end
        end
        far_dist = dist_reg[0];
        far_sel  = KEEP_COUNT'(1);
        for (int i = 1; i < KEEP_COUNT; i++)
        begin
            if (dist_reg[i] > far_dist)
            begin
                far_dist = dist_reg[i];
                far_sel  = KEEP_COUNT'(1) << i;
            end
        end
        if (!cmd.offer)
            wr_sel = '0;
        else if (found)
            wr_sel = empty_sel;
        else if (cand_dist < far_dist)
            wr_sel = far_sel;
        else
            wr_sel = '0;
    end

    always_comb
    begin
        if (cmd.clear)
            valid_next = '0;
        else
            valid_next = valid_reg | wr_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            if (wr_sel[i])
            begin
                slot_reg[i] <= cand;
                dist_reg[i] <= cand_dist;
            end
        end
    end

    assign slots      = slot_reg;
    assign slot_valid = valid_reg;

endmodule

>>> sv/nearest_three_neighbour_select.sv
// top level: keeps the nearest flock members and predators around a query point
// pipeline: a request passes an input stage and an update stage, which writes the slots
// throughput: one request per cycle; a finish snapshots 2*KEEP_COUNT results, sent one
// per cycle with out_ready high; later requests flow until a second finish must wait
// reset: slots empty, query point (0, 0), ranges 800 and 10240, no results pending
`timescale 1ns / 1ps

module nearest_three_neighbour_select #(
    parameter int KEEP_COUNT = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [nts_pkg::RADIUS_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic signed [nts_pkg::COORD_W-1:0]  query_x,
    input  logic signed [nts_pkg::COORD_W-1:0]  query_y,
    input  logic signed [nts_pkg::COORD_W-1:0]  point_x,
    input  logic signed [nts_pkg::COORD_W-1:0]  point_y,
    input  logic signed [nts_pkg::COORD_W-1:0]  point_vx,
    input  logic signed [nts_pkg::COORD_W-1:0]  point_vy,
    input  logic                                is_predator,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [nts_pkg::COORD_W-1:0]  slot_x,
    output logic signed [nts_pkg::COORD_W-1:0]  slot_y,
    output logic signed [nts_pkg::COORD_W-1:0]  slot_vx,
    output logic signed [nts_pkg::COORD_W-1:0]  slot_vy,
    output logic                                from_flock,
    output logic                                last_slot
);

    localparam int OUT_COUNT = 2 * KEEP_COUNT;
    localparam int CNT_W     = $clog2(OUT_COUNT + 1);

    // configuration
    logic [nts_pkg::RADIUS_W-1:0] awareness_reg;
    logic [nts_pkg::RADIUS_W-1:0] predator_reg;

    // query point
    logic signed [nts_pkg::COORD_W-1:0] query_x_reg;
    logic signed [nts_pkg::COORD_W-1:0] query_y_reg;

    // input stage
    logic                               a_valid_reg;
    logic [1:0]                         a_mode_reg;
    logic signed [nts_pkg::COORD_W-1:0] a_qx_reg;
    logic signed [nts_pkg::COORD_W-1:0] a_qy_reg;
    nts_pkg::slot_t                     a_point_reg;
    logic                               a_pred_reg;
    logic                               a_ready;
    logic                               a_fire;

    // update stage
    logic                               b_valid_reg;
    logic [1:0]                         b_mode_reg;
    logic [nts_pkg::SQ_W-1:0]           b_sqx_reg;
    logic [nts_pkg::SQ_W-1:0]           b_sqy_reg;
    logic [nts_pkg::RSQ_W-1:0]          b_rsq_reg;
    nts_pkg::slot_t                     b_point_reg;
    logic                               b_pred_reg;
    logic                               b_ready;
    logic                               b_fire;

    // squares
    logic signed [nts_pkg::DIFF_W-1:0]  dx;
    logic signed [nts_pkg::DIFF_W-1:0]  dy;
    logic signed [2*nts_pkg::DIFF_W-1:0] sqx_full;
    logic signed [2*nts_pkg::DIFF_W-1:0] sqy_full;
    logic [nts_pkg::RADIUS_W-1:0]       range_sel;
    logic [nts_pkg::RSQ_W-1:0]          rsq;

    // range check
    logic [nts_pkg::DIST_W-1:0]         dist_sum;
    logic                               in_range;

    // banks
    nts_pkg::bank_cmd_t                 flock_cmd;
    nts_pkg::bank_cmd_t                 pred_cmd;
    nts_pkg::slot_t [KEEP_COUNT-1:0]    flock_slots;
    nts_pkg::slot_t [KEEP_COUNT-1:0]    pred_slots;
    logic [KEEP_COUNT-1:0]              flock_valid;
    logic [KEEP_COUNT-1:0]              pred_valid;

    // result buffer
    nts_pkg::slot_t [OUT_COUNT-1:0]     buf_reg;
    nts_pkg::slot_t [OUT_COUNT-1:0]     buf_load;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               out_fire;
    logic                               buf_free;
    logic                               buf_take;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awareness_reg <= nts_pkg::AWARENESS_RESET;
            predator_reg  <= nts_pkg::PREDATOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (nts_pkg::cfg_reg_t'(cfg_index))
                nts_pkg::REG_AWARENESS: awareness_reg <= cfg_data;
                nts_pkg::REG_PREDATOR:  predator_reg  <= cfg_data;
                default:                awareness_reg <= awareness_reg;
            endcase
        end
    end

    // handshake chain
    assign out_fire = out_valid && out_ready;
    assign buf_free = (count_reg == '0) || (out_fire && count_reg == CNT_W'(1));
    assign b_ready  = !b_valid_reg || (b_mode_reg != nts_pkg::MODE_FINISH) || buf_free;
    assign b_fire   = b_valid_reg && b_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_fire   = a_valid_reg && b_ready;
    assign in_ready = a_ready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_mode_reg  <= mode;
            a_qx_reg    <= query_x;
            a_qy_reg    <= query_y;
            a_point_reg <= '{x: point_x, y: point_y, vx: point_vx, vy: point_vy};
            a_pred_reg  <= is_predator;
        end
    end

    // query point follows a begin request as it leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end
        else if (a_fire && a_mode_reg == nts_pkg::MODE_BEGIN)
        begin
            query_x_reg <= a_qx_reg;
            query_y_reg <= a_qy_reg;
        end
    end

    // squared offsets and squared range
    assign dx        = nts_pkg::DIFF_W'(a_point_reg.x) - nts_pkg::DIFF_W'(query_x_reg);
    assign dy        = nts_pkg::DIFF_W'(a_point_reg.y) - nts_pkg::DIFF_W'(query_y_reg);
    assign sqx_full  = dx * dx;
    assign sqy_full  = dy * dy;
    assign range_sel = a_pred_reg ? predator_reg : awareness_reg;
    assign rsq       = range_sel * range_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_mode_reg  <= a_mode_reg;
            b_sqx_reg   <= sqx_full[nts_pkg::SQ_W-1:0];
            b_sqy_reg   <= sqy_full[nts_pkg::SQ_W-1:0];
            b_rsq_reg   <= rsq;
            b_point_reg <= a_point_reg;
            b_pred_reg  <= a_pred_reg;
        end
    end

    // update stage
    assign dist_sum = nts_pkg::DIST_W'(b_sqx_reg) + nts_pkg::DIST_W'(b_sqy_reg);
    assign in_range = (dist_sum != '0) && (dist_sum <= nts_pkg::DIST_W'(b_rsq_reg));

    always_comb
    begin
        flock_cmd.clear = b_fire && (b_mode_reg == nts_pkg::MODE_BEGIN);
        flock_cmd.offer = b_fire && (b_mode_reg == nts_pkg::MODE_POINT) && in_range
                          && !b_pred_reg;
        pred_cmd.clear  = flock_cmd.clear;
        pred_cmd.offer  = b_fire && (b_mode_reg == nts_pkg::MODE_POINT) && in_range
                          && b_pred_reg;
    end

    nts_slot_bank #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_flock_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (flock_cmd),
        .cand       (b_point_reg),
        .cand_dist  (dist_sum),
        .slots      (flock_slots),
        .slot_valid (flock_valid)
    );

    nts_slot_bank #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_pred_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pred_cmd),
        .cand       (b_point_reg),
        .cand_dist  (dist_sum),
        .slots      (pred_slots),
        .slot_valid (pred_valid)
    );

    // snapshot on finish, empty slots read as zero
    assign buf_take = b_fire && (b_mode_reg == nts_pkg::MODE_FINISH);

    always_comb
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            buf_load[i]              = flock_valid[i] ? flock_slots[i] : '0;
            buf_load[KEEP_COUNT + i] = pred_valid[i] ? pred_slots[i] : '0;
        end
    end

    always_comb
    begin
        if (buf_take)
            count_next = CNT_W'(OUT_COUNT);
        else if (out_fire)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (buf_take)
            buf_reg <= buf_load;
        else if (out_fire)
        begin
            for (int i = 0; i < OUT_COUNT - 1; i++)
                buf_reg[i] <= buf_reg[i + 1];
        end
    end

    assign out_valid  = (count_reg != '0);
    assign slot_x     = buf_reg[0].x;
    assign slot_y     = buf_reg[0].y;
    assign slot_vx    = buf_reg[0].vx;
    assign slot_vy    = buf_reg[0].vy;
    assign from_flock = (count_reg > CNT_W'(KEEP_COUNT));
    assign last_slot  = (count_reg == CNT_W'(1));

endmodule

>>> sv/nts_checker.sv
// port-level checker for the nearest neighbour selector, bound to the top level
`timescale 1ns / 1ps
`include "nearest_three_neighbour_select_macros.svh"

module nts_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [nts_pkg::COORD_W-1:0]  slot_x,
    input logic signed [nts_pkg::COORD_W-1:0]  slot_y,
    input logic                                from_flock,
    input logic                                last_slot
);

    // stalled result holds
    `NTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot_x) && $stable(slot_y) && $stable(last_slot) && $stable(from_flock), "stalled result changed")

    // the final result is a predator slot
    `NTS_ASSERT_NOW(a_last_pred, out_valid && last_slot, !from_flock, "last result marked as flock")

    // a burst runs without gaps until its last result
    `NTS_ASSERT_NEXT(a_burst, out_valid && out_ready && !last_slot, out_valid, "gap inside a result burst")

    // once predator results start, flock results do not return within the burst
    `NTS_ASSERT_NEXT(a_group_order, out_valid && out_ready && !last_slot && !from_flock, out_valid && !from_flock, "flock result after predator result")

endmodule

bind nearest_three_neighbour_select nts_checker u_nts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot_x     (slot_x),
    .slot_y     (slot_y),
    .from_flock (from_flock),
    .last_slot  (last_slot)
);

>>> tb/sv/nearest_three_neighbour_select_tb.sv
// self-checking testbench for the nearest three neighbour selector
`timescale 1ns / 1ps

module nearest_three_neighbour_select_tb;

    import nts_pkg::*;

    localparam int KEEP = 3;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_REQUESTS = 62;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t vx;
        coord_t vy;
        longint sq_dist;
        bit     occupied;
    } kept_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t vx;
        coord_t vy;
        bit     flock;
        bit     last;
    } emitted_t;

    class neighbour_board;
        kept_t               banks[2][KEEP];   // flock, then predator
        coord_t              centre_x;
        coord_t              centre_y;
        logic [RADIUS_W-1:0] flock_limit;
        logic [RADIUS_W-1:0] predator_limit;
        emitted_t            awaited[$];
        int                  failures;
        int                  checked;
        int                  finishes;

        function new();
            centre_x = '0;
            centre_y = '0;
            flock_limit = AWARENESS_RESET;
            predator_limit = PREDATOR_RESET;
            failures = 0;
            checked = 0;
            finishes = 0;
            clear_banks();
        endfunction

        function void clear_banks();
            foreach (banks[b, i])
                banks[b][i] = '{default: 0};
        endfunction

        function void set_limit(cfg_reg_t idx, logic [RADIUS_W-1:0] value);
            if (idx == REG_AWARENESS)
                flock_limit = value;
            else
                predator_limit = value;
        endfunction

        function void keep_nearest(int b, coord_t px, coord_t py, coord_t vx, coord_t vy,
                                   longint d);
            int pick;
            pick = -1;
            for (int i = 0; i < KEEP; i++)
            begin
                if (!banks[b][i].occupied)
                begin
                    pick = i;
                    break;
                end
            end
            if (pick < 0)
            begin
                pick = 0;
                for (int i = 1; i < KEEP; i++)
                begin
                    if (banks[b][i].sq_dist > banks[b][pick].sq_dist)
                        pick = i;
                end
                if (!(d < banks[b][pick].sq_dist))
                    return;
            end
            banks[b][pick] = '{x: px, y: py, vx: vx, vy: vy, sq_dist: d, occupied: 1'b1};
        endfunction

        function void note_request(logic [1:0] m, coord_t qx, coord_t qy, coord_t px,
                                   coord_t py, coord_t vx, coord_t vy, logic pred);
            longint   dx;
            longint   dy;
            longint   d;
            longint   reach;
            emitted_t e;
            case (m)
                MODE_BEGIN:
                begin
                    centre_x = qx;
                    centre_y = qy;
                    clear_banks();
                end
                MODE_POINT:
                begin
                    dx = longint'(px) - longint'(centre_x);
                    dy = longint'(py) - longint'(centre_y);
                    d = dx * dx + dy * dy;
                    reach = pred ? longint'(predator_limit) : longint'(flock_limit);
                    if (d != 0 && d <= reach * reach)
                        keep_nearest(pred ? 1 : 0, px, py, vx, vy, d);
                end
                MODE_FINISH:
                begin
                    finishes++;
                    for (int b = 0; b < 2; b++)
                    begin
                        for (int i = 0; i < KEEP; i++)
                        begin
                            if (banks[b][i].occupied)
                            begin
                                e.x = banks[b][i].x;
                                e.y = banks[b][i].y;
                                e.vx = banks[b][i].vx;
                                e.vy = banks[b][i].vy;
                            end
                            else
                            begin
                                e.x = '0;
                                e.y = '0;
                                e.vx = '0;
                                e.vy = '0;
                            end
                            e.flock = (b == 0);
                            e.last = (b == 1 && i == KEEP - 1);
                            awaited.push_back(e);
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic signed [COORD_W-1:0] want,
                                    logic signed [COORD_W-1:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_slot(coord_t x, coord_t y, coord_t vx, coord_t vy,
                                 logic flock, logic last);
            emitted_t e;
            if (awaited.size() == 0)
            begin
                $error("slot result with no finish outstanding");
                failures++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            compare_field("slot_x", e.x, x);
            compare_field("slot_y", e.y, y);
            compare_field("slot_vx", e.vx, vx);
            compare_field("slot_vy", e.vy, vy);
            compare_field("from_flock", e.flock, flock);
            compare_field("last_slot", e.last, last);
        endfunction

        function void report_missing();
            if (awaited.size() != 0)
            begin
                $error("%0d slot results never arrived", awaited.size());
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [RADIUS_W-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          mode;
    coord_t              query_x;
    coord_t              query_y;
    coord_t              point_x;
    coord_t              point_y;
    coord_t              point_vx;
    coord_t              point_vy;
    logic                is_predator;
    logic                out_valid;
    logic                out_ready;
    coord_t              slot_x;
    coord_t              slot_y;
    coord_t              slot_vx;
    coord_t              slot_vy;
    logic                from_flock;
    logic                last_slot;

    neighbour_board board = new();
    bit hold_output = 1'b0;
    bit calm = 1'b0;
    int requests = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    nearest_three_neighbour_select #(
        .KEEP_COUNT(KEEP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .query_x(query_x),
        .query_y(query_y),
        .point_x(point_x),
        .point_y(point_y),
        .point_vx(point_vx),
        .point_vy(point_vy),
        .is_predator(is_predator),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot_x(slot_x),
        .slot_y(slot_y),
        .slot_vx(slot_vx),
        .slot_vy(slot_vy),
        .from_flock(from_flock),
        .last_slot(last_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic coord_t clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return coord_t'(v);
    endfunction

    function automatic int tie_step();
        if ($urandom_range(0, 7) == 0)
            return 0;
        return (int'($urandom_range(3, 5))) * ($urandom_range(0, 1) ? 1 : -1);
    endfunction

    task automatic send(logic [1:0] m, coord_t qx, coord_t qy, coord_t px, coord_t py,
                        coord_t vx, coord_t vy, logic pred);
        int gap;
        in_valid <= 1'b1;
        mode <= m;
        query_x <= qx;
        query_y <= qy;
        point_x <= px;
        point_y <= py;
        point_vx <= vx;
        point_vy <= vy;
        is_predator <= pred;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(m, qx, qy, px, py, vx, vy, pred);
        requests++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(logic [1:0] m);
        send(m, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'($urandom));
    endtask

    // mostly near the current query point so that the range limits and ties matter
    task automatic send_candidate();
        coord_t px;
        coord_t py;
        int     span;
        int     style;
        bit     pred;
        pred = ($urandom_range(0, 2) == 0);
        span = pred ? int'(board.predator_limit) : int'(board.flock_limit);
        span = span + span / 8 + 1;
        style = $urandom_range(0, 7);
        if (style == 0)
        begin
            px = coord_t'($urandom);
            py = coord_t'($urandom);
        end
        else if (style < 3)
        begin
            px = clamp16(int'(board.centre_x) + tie_step());
            py = clamp16(int'(board.centre_y) + tie_step());
        end
        else
        begin
            px = clamp16(int'(board.centre_x) + int'($urandom_range(0, 2 * span)) - span);
            py = clamp16(int'(board.centre_y) + int'($urandom_range(0, 2 * span)) - span);
        end
        send(MODE_POINT, coord_t'($urandom), coord_t'($urandom), px, py,
             coord_t'($urandom), coord_t'($urandom), pred);
    endtask

    task automatic write_limit(cfg_reg_t idx, logic [RADIUS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_limit(idx, value);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int quota);
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_random(MODE_BEGIN);
                n = $urandom_range(1, 9);
                repeat (n) send_candidate();
                send_random(MODE_FINISH);
                sent += n + 2;
                if ($urandom_range(0, 5) == 0)
                begin
                    send_random(MODE_FINISH);
                    sent++;
                end
            end
            else
            begin
                r = $urandom_range(0, 3);
                send_random(2'(r));
                if (2'(r) != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
                if (pick_gap() > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (pick_gap() + 1) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_slot(slot_x, slot_y, slot_vx, slot_vy, from_flock, last_slot);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles", quiet_cycles);
            $display("FAIL nearest_three_neighbour_select");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        in_valid <= 1'b0;
        mode <= MODE_BEGIN;
        query_x <= '0;
        query_y <= '0;
        point_x <= '0;
        point_y <= '0;
        point_vx <= '0;
        point_vy <= '0;
        is_predator <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_AWARENESS;
        cfg_data <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // candidate before any begin, measured from the origin
        send(MODE_POINT, 0, 0, 30, 40, 7, -7, 1'b0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
        send(MODE_BEGIN, 100, -100, 0, 0, 0, 0, 1'b0);
        // zero distance, then exactly on and just past the flock limit
        send(MODE_POINT, 0, 0, 100, -100, 1, 1, 1'b0);
        send(MODE_POINT, 0, 0, 900, -100, 2, 2, 1'b0);
        send(MODE_POINT, 0, 0, 901, -100, 3, 3, 1'b0);
        send(MODE_POINT, 0, 0, 100, 500, 4, 4, 1'b0);
        send(MODE_POINT, 0, 0, -200, -100, 5, 5, 1'b0);
        // full bank: replace farthest, equal distance kept out, tie goes to lowest slot
        send(MODE_POINT, 0, 0, 100, -700, 6, 6, 1'b0);
        send(MODE_POINT, 0, 0, -500, -100, 7, 7, 1'b0);
        send(MODE_POINT, 0, 0, 200, -100, 8, 8, 1'b0);
        // predators: far corner, exactly on the limit, extreme velocities
        send(MODE_POINT, 0, 0, -32768, -32768, 9, 9, 1'b1);
        send(MODE_POINT, 0, 0, 10340, -100, 10, 10, 1'b1);
        send(MODE_POINT, 0, 0, 100, 50, 32767, -32768, 1'b1);
        send(MODE_UNUSED, -1, -1, -1, -1, -1, -1, 1'b1);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
        send(MODE_FINISH, -1, -1, -1, -1, -1, -1, 1'b1);
        send(MODE_BEGIN, -32768, 32767, 0, 0, 0, 0, 1'b0);
        send(MODE_POINT, 0, 0, 32767, -32768, 11, 11, 1'b1);
        send(MODE_POINT, 0, 0, -32765, 32763, -32768, 32767, 1'b0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
        send(MODE_BEGIN, 32767, -32768, 0, 0, 0, 0, 1'b0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0, 1'b0);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_limit(REG_AWARENESS, '1);
                    write_limit(REG_PREDATOR, '0);
                    hold_output = 1'b1;
                end
                1:
                begin
                    write_limit(REG_AWARENESS, '0);
                    write_limit(REG_PREDATOR, '1);
                end
                2:
                begin
                    write_limit(REG_AWARENESS, RADIUS_W'($urandom));
                    write_limit(REG_PREDATOR, RADIUS_W'($urandom));
                    calm = 1'b1;
                end
                default:
                begin
                    write_limit(REG_AWARENESS, RADIUS_W'($urandom_range(1, 64)));
                    write_limit(REG_PREDATOR, RADIUS_W'($urandom_range(0, 4000)));
                    calm = 1'b0;
                end
            endcase
            run_phase(PHASE_REQUESTS);
            settle();
        end

        board.report_missing();
        $display("covered %0d requests over directed cases and four range settings,",
                 requests);
        $display("%0d finishes, %0d slots checked, %0d register writes, one long output hold",
                 board.finishes, board.checked, cfg_writes);
        if (board.failures == 0)
            $display("PASS nearest_three_neighbour_select");
        else
            $display("FAIL nearest_three_neighbour_select");
        $finish;
    end

endmodule
